FILE: rtl/gcs_pkg.sv
// shared types and constants of the gas chamber switch controller
`default_nettype none
package gcs_pkg;

  // divider operand widths: sums of up to sixteen 16-bit readings, counts up to 16
  localparam int unsigned DIV_W = 21;
  localparam int unsigned DEN_W = 5;
  localparam int unsigned CNT_W = 5;

  localparam logic [3:0] ALL_OPEN_CODE = 4'd15;
  localparam logic [3:0] DUAL_OFFSET   = 4'd3;
  localparam logic [15:0] START_MIN    = 16'hFFFF;

  localparam logic [2:0] MODE_NONE     = 3'd0;
  localparam logic [2:0] MODE_PERIODIC = 3'd1;
  localparam logic [2:0] MODE_ADAPTIVE = 3'd2;
  localparam logic [2:0] MODE_ALL_OPEN = 3'd3;
  localparam logic [2:0] MODE_DUAL     = 3'd4;

  localparam logic CMD_READING = 1'b0;
  localparam logic CMD_FORCED  = 1'b1;

  typedef enum logic [2:0] {
    CFG_STRATEGY_MODE   = 3'd0,
    CFG_MONITORED_TYPE  = 3'd1,
    CFG_MIN_ACTIVE_MS   = 3'd2,
    CFG_DECAY_THRESHOLD = 3'd3,
    CFG_MIN_DIFFERENCE  = 3'd4,
    CFG_CHAMBERS_IN_USE = 3'd5,
    CFG_SENSORS_IN_USE  = 3'd6
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DETECT,
    S_A_RD,
    S_A_DT,
    S_A_MEAN,
    S_STRAT,
    S_ADAPT,
    S_AD_CUR,
    S_AD_CMP,
    S_AD_PEAK,
    S_SW_INIT,
    S_SW_RD,
    S_SW_DT,
    S_SW_MEAN,
    S_SW_NEXT,
    S_SW_END,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic        command;
    logic [2:0]  chamber_index;
    logic [3:0]  sensor_slot;
    logic [15:0] sensor_type;
    logic [15:0] voltage;
    logic        chamber_active;
    logic        last_reading;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  active_chamber;
    logic        active_found;
    logic [15:0] monitored_average;
    logic        send_command;
    logic [3:0]  chamber_command;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/gcs_if.sv
// valid/ready channel interfaces for input and result beats
`default_nettype none
interface gcs_in_if;
  logic               valid;
  logic               ready;
  gcs_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gcs_out_if;
  logic               valid;
  logic               ready;
  gcs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/gas_chamber_switch_controller.sv
// Gas chamber switch controller: a non-final reading is taken in the idle state; a final
// reading or forced request runs the active chamber scan over its S sensors,
// plus divisions in the shared bit-serial divider (chamber mean, window averages)
// and a sensor scan (with a mean division where used) per chamber of a switch search.
// Throughput one observation at a time; the block is not ready while it evaluates.
// Reset clears flags, windows, averages, switch time and registers; the store is unset.
`default_nettype none
module gas_chamber_switch_controller #(
  parameter int unsigned MAX_CHAMBERS = 4,
  parameter int unsigned MAX_SENSORS  = 8,
  parameter int unsigned WINDOW_DEPTH = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  gcs_in_if.sink           in_i,
  gcs_out_if.source        out_o
);
  localparam int unsigned DEPTH = MAX_CHAMBERS * MAX_SENSORS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned DW    = gcs_pkg::DIV_W;
  localparam int unsigned CW    = $clog2(WINDOW_DEPTH + 1);

  gcs_pkg::state_e state_q, state_d, ret_q, ret_d;

  // configuration
  logic [2:0]  mode_q, mode_d;
  logic [15:0] mtype_q, mtype_d;
  logic [31:0] min_ms_q, min_ms_d;
  logic [15:0] decay_q, decay_d;
  logic [15:0] mindiff_q, mindiff_d;
  logic [3:0]  nch_cfg_q, nch_cfg_d;
  logic [4:0]  nsn_cfg_q, nsn_cfg_d;

  // persistent state
  logic [7:0]  flags_q, flags_d;
  logic [15:0] rwin_q [WINDOW_DEPTH];
  logic [15:0] rwin_d [WINDOW_DEPTH];
  logic [15:0] pwin_q [WINDOW_DEPTH];
  logic [15:0] pwin_d [WINDOW_DEPTH];
  logic [CW-1:0] rcnt_q, rcnt_d, pcnt_q, pcnt_d;
  logic [DW-1:0] rsum_q, rsum_d, psum_q, psum_d;
  logic [15:0] peak_q, peak_d, cur_q, cur_d;
  logic [31:0] last_q, last_d;

  // per-observation scratch
  logic        cmd_q, cmd_d;
  logic [31:0] now_q, now_d;
  logic [2:0]  ac_q, ac_d;
  logic        found_q, found_d;
  logic [4:0]  j_q, j_d;
  logic [3:0]  ch_q, ch_d;
  logic [DW-1:0] sum_q, sum_d;
  logic        match_q, match_d;
  logic [15:0] mval_q, mval_d;
  logic [15:0] reading_q, reading_d;
  logic        tia_q, tia_d;
  logic        forced_q, forced_d, dual_q, dual_d, umean_q, umean_d;
  logic [3:0]  best_q, best_d;
  logic [16:0] minv_q, minv_d;
  logic        send_q, send_d;
  logic [3:0]  code_q, code_d;
  logic [DW-1:0] num_q, num_d;
  logic [gcs_pkg::DEN_W-1:0] den_q, den_d;
  gcs_pkg::out_item_t odata_q, odata_d;
  logic        ovalid_q, ovalid_d;

  logic [3:0]  nch;
  logic [4:0]  nsn;
  logic        in_fire, out_fire, out_free, elapsed_gt;
  logic [31:0] rdata;
  logic [15:0] rd_volt, rd_type;
  logic [7:0]  waddr_full, raddr_full;
  logic [2:0]  rd_ch;
  logic        wr_en;
  logic [2:0]  det_ac;
  logic        det_found;
  logic        j_last;
  gcs_pkg::div_req_t div_req;
  gcs_pkg::div_rsp_t div_rsp;

  always_comb begin
    nch = nch_cfg_q;
    if (nch < 4'd2) nch = 4'd2;
    if (nch > 4'(MAX_CHAMBERS)) nch = 4'(MAX_CHAMBERS);
    nsn = nsn_cfg_q;
    if (nsn < 5'd1) nsn = 5'd1;
    if (nsn > 5'(MAX_SENSORS)) nsn = 5'(MAX_SENSORS);
  end

  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;
  assign out_free   = !ovalid_q || out_o.ready;
  assign elapsed_gt = (now_q - last_q) > min_ms_q;
  assign j_last     = (j_q + 5'd1) == nsn;
  assign rd_volt    = rdata[15:0];
  assign rd_type    = rdata[31:16];

  // lowest flagged chamber among those in use
  always_comb begin
    det_ac    = 3'd0;
    det_found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (flags_q[i] && (4'(i) < nch)) begin
        det_ac    = 3'(i);
        det_found = 1'b1;
      end
    end
  end

  assign wr_en = in_fire && (in_i.data.command == gcs_pkg::CMD_READING) &&
                 (4'(in_i.data.chamber_index) < 4'(MAX_CHAMBERS)) &&
                 (5'(in_i.data.sensor_slot) < 5'(MAX_SENSORS));
  assign waddr_full = 8'(in_i.data.chamber_index) * 8'(MAX_SENSORS) +
                      8'(in_i.data.sensor_slot);
  assign rd_ch      = (state_q == gcs_pkg::S_SW_RD) ? ch_q[2:0] : ac_q;
  assign raddr_full = 8'(rd_ch) * 8'(MAX_SENSORS) + 8'(j_q[3:0]);

  gcs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr_full[AW-1:0]),
    .wdata_i ({in_i.data.sensor_type, in_i.data.voltage}),
    .raddr_i (raddr_full[AW-1:0]),
    .rdata_o (rdata)
  );

  gcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gcs_pkg::S_IDLE: begin
        if (in_fire && ((in_i.data.command == gcs_pkg::CMD_FORCED) ||
                        in_i.data.last_reading)) begin
          state_d = gcs_pkg::S_DETECT;
        end
      end
      gcs_pkg::S_DETECT: state_d = gcs_pkg::S_A_RD;
      gcs_pkg::S_A_RD:   state_d = gcs_pkg::S_A_DT;
      gcs_pkg::S_A_DT: begin
        if (!j_last) state_d = gcs_pkg::S_A_RD;
        else if (match_q || (mtype_q != 16'd0 && rd_type == mtype_q)) state_d = gcs_pkg::S_STRAT;
        else state_d = gcs_pkg::S_DIV_GO;
      end
      gcs_pkg::S_A_MEAN: state_d = gcs_pkg::S_STRAT;
      gcs_pkg::S_STRAT: begin
        if (cmd_q == gcs_pkg::CMD_FORCED) begin
          state_d = gcs_pkg::S_SW_INIT;
        end else begin
          case (mode_q)
            gcs_pkg::MODE_ADAPTIVE: state_d = gcs_pkg::S_ADAPT;
            gcs_pkg::MODE_DUAL: begin
              state_d = (ac_q == 3'd0) ? gcs_pkg::S_SW_INIT : gcs_pkg::S_ADAPT;
            end
            default: state_d = gcs_pkg::S_DONE;
          endcase
        end
      end
      gcs_pkg::S_ADAPT:  state_d = gcs_pkg::S_DIV_GO;
      gcs_pkg::S_AD_CUR: state_d = gcs_pkg::S_AD_CMP;
      gcs_pkg::S_AD_CMP: begin
        if (cur_q > peak_q) state_d = gcs_pkg::S_DIV_GO;
        else if ((17'(peak_q) > 17'(cur_q) + 17'(decay_q)) && elapsed_gt)
          state_d = gcs_pkg::S_SW_INIT;
        else state_d = gcs_pkg::S_DONE;
      end
      gcs_pkg::S_AD_PEAK: state_d = gcs_pkg::S_DONE;
      gcs_pkg::S_SW_INIT: state_d = gcs_pkg::S_SW_RD;
      gcs_pkg::S_SW_RD:   state_d = gcs_pkg::S_SW_DT;
      gcs_pkg::S_SW_DT: begin
        if (!j_last) state_d = gcs_pkg::S_SW_RD;
        else if (umean_q) state_d = gcs_pkg::S_DIV_GO;
        else state_d = gcs_pkg::S_SW_NEXT;
      end
      gcs_pkg::S_SW_MEAN: state_d = gcs_pkg::S_SW_NEXT;
      gcs_pkg::S_SW_NEXT: begin
        state_d = ((ch_q + 4'd1) < nch) ? gcs_pkg::S_SW_RD : gcs_pkg::S_SW_END;
      end
      gcs_pkg::S_SW_END: state_d = gcs_pkg::S_DONE;
      gcs_pkg::S_DIV_GO: state_d = gcs_pkg::S_DIV_WAIT;
      gcs_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) state_d = ret_q;
      end
      gcs_pkg::S_DONE: begin
        if (out_free) state_d = gcs_pkg::S_IDLE;
      end
      default: state_d = gcs_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready       = (state_q == gcs_pkg::S_IDLE);
    out_o.valid      = ovalid_q;
    out_o.data       = odata_q;
    div_req.start    = (state_q == gcs_pkg::S_DIV_GO);
    div_req.dividend = num_q;
    div_req.divisor  = den_q;
  end

  // datapath
  always_comb begin
    logic [16:0] mean17;
    logic [3:0]  nxt;
    mean17    = {1'b0, div_rsp.quotient[15:0]};
    nxt       = 4'd0;
    mode_d    = mode_q;
    mtype_d   = mtype_q;
    min_ms_d  = min_ms_q;
    decay_d   = decay_q;
    mindiff_d = mindiff_q;
    nch_cfg_d = nch_cfg_q;
    nsn_cfg_d = nsn_cfg_q;
    flags_d   = flags_q;
    rwin_d    = rwin_q;
    pwin_d    = pwin_q;
    rcnt_d    = rcnt_q;
    pcnt_d    = pcnt_q;
    rsum_d    = rsum_q;
    psum_d    = psum_q;
    peak_d    = peak_q;
    cur_d     = cur_q;
    last_d    = last_q;
    cmd_d     = cmd_q;
    now_d     = now_q;
    ac_d      = ac_q;
    found_d   = found_q;
    j_d       = j_q;
    ch_d      = ch_q;
    sum_d     = sum_q;
    match_d   = match_q;
    mval_d    = mval_q;
    reading_d = reading_q;
    tia_d     = tia_q;
    forced_d  = forced_q;
    dual_d    = dual_q;
    umean_d   = umean_q;
    best_d    = best_q;
    minv_d    = minv_q;
    send_d    = send_q;
    code_d    = code_q;
    num_d     = num_q;
    den_d     = den_q;
    ret_d     = ret_q;
    odata_d   = odata_q;
    ovalid_d  = ovalid_q && !out_fire;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        gcs_pkg::CFG_STRATEGY_MODE:   mode_d    = cfg_data_i[2:0];
        gcs_pkg::CFG_MONITORED_TYPE:  mtype_d   = cfg_data_i[15:0];
        gcs_pkg::CFG_MIN_ACTIVE_MS:   min_ms_d  = cfg_data_i;
        gcs_pkg::CFG_DECAY_THRESHOLD: decay_d   = cfg_data_i[15:0];
        gcs_pkg::CFG_MIN_DIFFERENCE:  mindiff_d = cfg_data_i[15:0];
        gcs_pkg::CFG_CHAMBERS_IN_USE: nch_cfg_d = cfg_data_i[3:0];
        gcs_pkg::CFG_SENSORS_IN_USE:  nsn_cfg_d = cfg_data_i[4:0];
        default: ;
      endcase
    end

    case (state_q)
      gcs_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd_d = in_i.data.command;
          now_d = in_i.data.now_ms;
          if (in_i.data.command == gcs_pkg::CMD_READING) begin
            flags_d[in_i.data.chamber_index] = in_i.data.chamber_active;
          end
        end
      end
      gcs_pkg::S_DETECT: begin
        ac_d    = det_ac;
        found_d = det_found;
        j_d     = 5'd0;
        sum_d   = '0;
        match_d = 1'b0;
        send_d  = 1'b0;
        code_d  = 4'd0;
      end
      gcs_pkg::S_A_DT: begin
        sum_d = sum_q + DW'(rd_volt);
        j_d   = j_q + 5'd1;
        if (!match_q && mtype_q != 16'd0 && rd_type == mtype_q) begin
          match_d = 1'b1;
          mval_d  = rd_volt;
        end
        if (j_last) begin
          if (match_d) begin
            reading_d = match_q ? mval_q : rd_volt;
            tia_d     = 1'b1;
          end else begin
            tia_d = 1'b0;
            num_d = sum_q + DW'(rd_volt);
            den_d = nsn;
            ret_d = gcs_pkg::S_A_MEAN;
          end
        end
      end
      gcs_pkg::S_A_MEAN: reading_d = div_rsp.quotient[15:0];
      gcs_pkg::S_STRAT: begin
        forced_d = 1'b0;
        dual_d   = 1'b0;
        if (cmd_q == gcs_pkg::CMD_FORCED) begin
          forced_d = 1'b1;
        end else begin
          case (mode_q)
            gcs_pkg::MODE_PERIODIC: begin
              if (elapsed_gt) begin
                nxt = 4'(ac_q) + 4'd1;
                if (nxt >= nch) nxt = 4'd0;
                send_d = 1'b1;
                code_d = nxt;
                last_d = now_q;
              end
            end
            gcs_pkg::MODE_ALL_OPEN: begin
              send_d = 1'b1;
              code_d = gcs_pkg::ALL_OPEN_CODE;
            end
            gcs_pkg::MODE_DUAL: begin
              dual_d   = 1'b1;
              forced_d = (ac_q == 3'd0);
            end
            default: ;
          endcase
        end
      end
      gcs_pkg::S_ADAPT: begin
        // push into the recent window with a running sum
        if (rcnt_q == CW'(WINDOW_DEPTH)) begin
          for (int i = 0; i < WINDOW_DEPTH - 1; i++) rwin_d[i] = rwin_q[i+1];
          rwin_d[WINDOW_DEPTH-1] = reading_q;
          rsum_d = rsum_q - DW'(rwin_q[0]) + DW'(reading_q);
        end else begin
          for (int i = 0; i < WINDOW_DEPTH; i++) begin
            if (rcnt_q == CW'(i)) rwin_d[i] = reading_q;
          end
          rcnt_d = rcnt_q + CW'(1);
          rsum_d = rsum_q + DW'(reading_q);
        end
        num_d = rsum_d;
        den_d = gcs_pkg::DEN_W'(rcnt_d);
        ret_d = gcs_pkg::S_AD_CUR;
      end
      gcs_pkg::S_AD_CUR: cur_d = div_rsp.quotient[15:0];
      gcs_pkg::S_AD_CMP: begin
        if (cur_q > peak_q) begin
          if (pcnt_q == CW'(WINDOW_DEPTH)) begin
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) pwin_d[i] = pwin_q[i+1];
            pwin_d[WINDOW_DEPTH-1] = reading_q;
            psum_d = psum_q - DW'(pwin_q[0]) + DW'(reading_q);
          end else begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
              if (pcnt_q == CW'(i)) pwin_d[i] = reading_q;
            end
            pcnt_d = pcnt_q + CW'(1);
            psum_d = psum_q + DW'(reading_q);
          end
          num_d = psum_d;
          den_d = gcs_pkg::DEN_W'(pcnt_d);
          ret_d = gcs_pkg::S_AD_PEAK;
        end
      end
      gcs_pkg::S_AD_PEAK: peak_d = div_rsp.quotient[15:0];
      gcs_pkg::S_SW_INIT: begin
        ch_d    = dual_q ? 4'd1 : 4'd0;
        best_d  = ch_d;
        umean_d = dual_q ? (mtype_q == 16'd0) : ((mtype_q == 16'd0) || !tia_q);
        // mean search takes the first chamber unconditionally
        minv_d  = umean_d ? 17'h10000 : {1'b0, gcs_pkg::START_MIN};
        j_d     = 5'd0;
        sum_d   = '0;
      end
      gcs_pkg::S_SW_DT: begin
        j_d = j_q + 5'd1;
        if (umean_q) begin
          sum_d = sum_q + DW'(rd_volt);
          if (j_last) begin
            num_d = sum_d;
            den_d = nsn;
            ret_d = gcs_pkg::S_SW_MEAN;
          end
        end else if (rd_type == mtype_q && {1'b0, rd_volt} < minv_q) begin
          minv_d = {1'b0, rd_volt};
          best_d = ch_q;
        end
      end
      gcs_pkg::S_SW_MEAN: begin
        if (mean17 < minv_q) begin
          minv_d = mean17;
          best_d = ch_q;
        end
      end
      gcs_pkg::S_SW_NEXT: begin
        ch_d  = ch_q + 4'd1;
        j_d   = 5'd0;
        sum_d = '0;
      end
      gcs_pkg::S_SW_END: begin
        if (forced_q || ((17'(cur_q) > minv_q) &&
                         ((17'(cur_q) - minv_q) > 17'(mindiff_q)))) begin
          send_d = 1'b1;
          code_d = best_q + (dual_q ? gcs_pkg::DUAL_OFFSET : 4'd0);
          last_d = now_q;
          peak_d = 16'd0;
          pcnt_d = '0;
          psum_d = '0;
        end
      end
      gcs_pkg::S_DONE: begin
        if (out_free) begin
          ovalid_d                  = 1'b1;
          odata_d.active_chamber    = ac_q;
          odata_d.active_found      = found_q;
          odata_d.monitored_average = cur_q;
          odata_d.send_command      = send_q;
          odata_d.chamber_command   = send_q ? code_q : 4'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gcs_pkg::S_IDLE;
      ret_q     <= gcs_pkg::S_IDLE;
      mode_q    <= gcs_pkg::MODE_NONE;
      mtype_q   <= '0;
      min_ms_q  <= '0;
      decay_q   <= '0;
      mindiff_q <= '0;
      nch_cfg_q <= 4'd4;
      nsn_cfg_q <= 5'd8;
      flags_q   <= '0;
      rcnt_q    <= '0;
      pcnt_q    <= '0;
      rsum_q    <= '0;
      psum_q    <= '0;
      peak_q    <= '0;
      cur_q     <= '0;
      last_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      mode_q    <= mode_d;
      mtype_q   <= mtype_d;
      min_ms_q  <= min_ms_d;
      decay_q   <= decay_d;
      mindiff_q <= mindiff_d;
      nch_cfg_q <= nch_cfg_d;
      nsn_cfg_q <= nsn_cfg_d;
      flags_q   <= flags_d;
      rcnt_q    <= rcnt_d;
      pcnt_q    <= pcnt_d;
      rsum_q    <= rsum_d;
      psum_q    <= psum_d;
      peak_q    <= peak_d;
      cur_q     <= cur_d;
      last_q    <= last_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rwin_q    <= rwin_d;
    pwin_q    <= pwin_d;
    cmd_q     <= cmd_d;
    now_q     <= now_d;
    ac_q      <= ac_d;
    found_q   <= found_d;
    j_q       <= j_d;
    ch_q      <= ch_d;
    sum_q     <= sum_d;
    match_q   <= match_d;
    mval_q    <= mval_d;
    reading_q <= reading_d;
    tia_q     <= tia_d;
    forced_q  <= forced_d;
    dual_q    <= dual_d;
    umean_q   <= umean_d;
    best_q    <= best_d;
    minv_q    <= minv_d;
    send_q    <= send_d;
    code_q    <= code_d;
    num_q     <= num_d;
    den_q     <= den_d;
    odata_q   <= odata_d;
  end
endmodule
`default_nettype wire

FILE: rtl/gcs_ram.sv
// generic single-write, single-read RAM with registered read data
`default_nettype none
module gcs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/gcs_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module gcs_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gcs_pkg::div_req_t req_i,
  output gcs_pkg::div_rsp_t      rsp_o
);
  localparam int unsigned DW = gcs_pkg::DIV_W;
  localparam int unsigned NW = gcs_pkg::DEN_W;

  logic [DW-1:0] quo_q, quo_d;
  logic [NW-1:0] rem_q, rem_d;
  logic [NW-1:0] den_q, den_d;
  logic [4:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [NW:0]   shifted;
  logic [NW:0]   trial;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[DW-1]};
    trial   = shifted - {1'b0, den_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
      cnt_d  = 5'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = trial[NW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = shifted[NW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule
`default_nettype wire

FILE: tb/tb.sv
// testbench for the gas chamber switch controller: directed table, random observations, scoreboard
`timescale 1ns / 1ps
module tb;
  import gcs_pkg::*;

  localparam int CH_MAX = 4;
  localparam int SN_MAX = 8;
  localparam int WIN = 10;
  localparam int SETTLE = 600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [31:0] cfg_data = '0;

  gcs_in_if  in_ch ();
  gcs_out_if out_ch ();

  gas_chamber_switch_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #10 clk_i = ~clk_i;

  // register copies
  logic [2:0]  mode_r;
  logic [15:0] mon_type_r;
  logic [31:0] min_ms_r;
  logic [15:0] decay_r;
  logic [15:0] min_diff_r;
  logic [3:0]  nch_r;
  logic [4:0]  nsens_r;

  // controller state copies
  logic [15:0] obs_volt [CH_MAX*SN_MAX];
  logic [15:0] obs_type [CH_MAX*SN_MAX];
  logic [7:0]  flag_bits;
  logic [15:0] recent_buf [WIN];
  int          recent_n;
  logic [15:0] peak_buf [WIN];
  int          peak_n;
  logic [15:0] peak_avg;
  logic [15:0] cur_avg;
  logic [31:0] last_sw;
  bit          cmd_sent;
  logic [3:0]  cmd_code;

  out_item_t expected_q [$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        n_items = 0;

  // stimulus shaping
  logic [31:0] clock_ms;
  int          level;
  int          level_dir;

  function automatic int eff_chambers();
    int n;
    n = nch_r;
    if (n < 2) n = 2;
    if (n > CH_MAX) n = CH_MAX;
    return n;
  endfunction

  function automatic int eff_sensors();
    int n;
    n = nsens_r;
    if (n < 1) n = 1;
    if (n > SN_MAX) n = SN_MAX;
    return n;
  endfunction

  function automatic logic [31:0] chamber_mean(int ch);
    logic [31:0] s;
    s = 0;
    for (int j = 0; j < eff_sensors(); j++) s += obs_volt[ch*SN_MAX+j];
    return s / eff_sensors();
  endfunction

  function automatic bit type_lookup(int ch, output logic [31:0] v);
    v = 0;
    for (int j = 0; j < eff_sensors(); j++)
      if (obs_type[ch*SN_MAX+j] == mon_type_r) begin
        v = obs_volt[ch*SN_MAX+j];
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic logic [15:0] window_push(inout logic [15:0] w [WIN], inout int cnt,
                                              input logic [31:0] v);
    logic [31:0] s;
    s = 0;
    if (cnt >= WIN) begin
      for (int i = 0; i < WIN - 1; i++) w[i] = w[i+1];
      cnt = WIN - 1;
    end
    w[cnt] = v[15:0];
    cnt++;
    for (int i = 0; i < cnt; i++) s += w[i];
    return 16'(s / cnt);
  endfunction

  function automatic void issue(logic [31:0] code);
    cmd_sent = 1'b1;
    cmd_code = code[3:0];
  endfunction

  function automatic void try_switch(bit forced, bit dual, bit tia, logic [31:0] now_ms);
    logic [31:0] minv, best, m;
    int first;
    bit use_mean;
    minv = 32'(START_MIN);
    first = dual ? 1 : 0;
    use_mean = dual ? (mon_type_r == 0) : (mon_type_r == 0 || !tia);
    best = first;
    if (use_mean) begin
      minv = chamber_mean(first);
      for (int ch = first + 1; ch < eff_chambers(); ch++) begin
        m = chamber_mean(ch);
        if (m < minv) begin
          minv = m;
          best = ch;
        end
      end
    end else begin
      for (int ch = first; ch < eff_chambers(); ch++)
        for (int j = 0; j < eff_sensors(); j++)
          if (obs_type[ch*SN_MAX+j] == mon_type_r && obs_volt[ch*SN_MAX+j] < minv) begin
            minv = obs_volt[ch*SN_MAX+j];
            best = ch;
          end
    end
    if (dual) best += DUAL_OFFSET;
    if (forced || (32'(cur_avg) > minv && 32'(cur_avg) - minv > 32'(min_diff_r))) begin
      issue(best);
      last_sw = now_ms;
      peak_avg = 0;
      peak_n = 0;
    end
  endfunction

  function automatic void adapt_step(logic [31:0] rd, bit dual, bit tia, logic [31:0] now_ms);
    cur_avg = window_push(recent_buf, recent_n, rd);
    if (cur_avg > peak_avg) begin
      peak_avg = window_push(peak_buf, peak_n, rd);
    end else if (32'(peak_avg) > 32'(cur_avg) + 32'(decay_r)) begin
      if (now_ms - last_sw > min_ms_r) try_switch(1'b0, dual, tia, now_ms);
    end
  endfunction

  // returns 1 when the beat yields a result
  function automatic bit predict_switch(in_item_t it, output out_item_t res);
    logic [31:0] rd, nx;
    bit found, tia;
    int ac;
    res = '0;
    cmd_sent = 1'b0;
    cmd_code = '0;
    if (it.command == CMD_READING) begin
      if (it.chamber_index < CH_MAX && it.sensor_slot < SN_MAX) begin
        obs_volt[it.chamber_index*SN_MAX+it.sensor_slot] = it.voltage;
        obs_type[it.chamber_index*SN_MAX+it.sensor_slot] = it.sensor_type;
      end
      flag_bits[it.chamber_index] = it.chamber_active;
      if (!it.last_reading) return 1'b0;
    end
    found = 1'b0;
    ac = 0;
    for (int c = 0; c < eff_chambers() && !found; c++)
      if (flag_bits[c]) begin
        found = 1'b1;
        ac = c;
      end
    tia = (mon_type_r != 0) && type_lookup(ac, rd);
    if (!tia) rd = chamber_mean(ac);
    if (it.command == CMD_FORCED) begin
      try_switch(1'b1, 1'b0, tia, it.now_ms);
    end else begin
      case (mode_r)
        MODE_PERIODIC: begin
          if (it.now_ms - last_sw > min_ms_r) begin
            nx = ac + 1;
            if (nx >= eff_chambers()) nx = 0;
            issue(nx);
            last_sw = it.now_ms;
          end
        end
        MODE_ADAPTIVE: adapt_step(rd, 1'b0, tia, it.now_ms);
        MODE_ALL_OPEN: issue(32'(ALL_OPEN_CODE));
        MODE_DUAL: begin
          if (ac == 0) try_switch(1'b1, 1'b1, tia, it.now_ms);
          else adapt_step(rd, 1'b1, tia, it.now_ms);
        end
        default: ;
      endcase
    end
    res.active_chamber = 3'(ac);
    res.active_found = found;
    res.monitored_average = cur_avg;
    res.send_command = cmd_sent;
    res.chamber_command = cmd_sent ? cmd_code : 4'd0;
    return 1'b1;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result beats
  always @(posedge clk_i) begin
    out_item_t w;
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected beat", out_ch.data, 0);
      end else begin
        w = expected_q.pop_front();
        if (out_ch.data.active_chamber !== w.active_chamber)
          report("active_chamber", out_ch.data.active_chamber, w.active_chamber);
        if (out_ch.data.active_found !== w.active_found)
          report("active_found", out_ch.data.active_found, w.active_found);
        if (out_ch.data.monitored_average !== w.monitored_average)
          report("monitored_average", out_ch.data.monitored_average, w.monitored_average);
        if (out_ch.data.send_command !== w.send_command)
          report("send_command", out_ch.data.send_command, w.send_command);
        if (out_ch.data.chamber_command !== w.chamber_command)
          report("chamber_command", out_ch.data.chamber_command, w.chamber_command);
      end
    end
  end

  // typed_ok selects the hand-written expectation over the predicted one
  task automatic drive_beat(in_item_t it, bit typed_ok = 1'b0, out_item_t typed = '0);
    out_item_t res;
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    n_items++;
    if (predict_switch(it, res)) expected_q.push_back(typed_ok ? typed : res);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // caller has the block idle; leaves the write enable high for a following write
  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      CFG_STRATEGY_MODE:   mode_r = val[2:0];
      CFG_MONITORED_TYPE:  mon_type_r = val[15:0];
      CFG_MIN_ACTIVE_MS:   min_ms_r = val;
      CFG_DECAY_THRESHOLD: decay_r = val[15:0];
      CFG_MIN_DIFFERENCE:  min_diff_r = val[15:0];
      CFG_CHAMBERS_IN_USE: nch_r = val[3:0];
      CFG_SENSORS_IN_USE:  nsens_r = val[4:0];
      default: ;
    endcase
  endtask

  function automatic in_item_t reading(int ch, int sl, logic [15:0] ty, logic [15:0] v,
                                       bit act, bit last, logic [31:0] now_ms);
    in_item_t it;
    it.command = CMD_READING;
    it.chamber_index = 3'(ch);
    it.sensor_slot = 4'(sl);
    it.sensor_type = ty;
    it.voltage = v;
    it.chamber_active = act;
    it.last_reading = last;
    it.now_ms = now_ms;
    return it;
  endfunction

  function automatic in_item_t forced_req(logic [31:0] now_ms);
    in_item_t it;
    it = '0;
    it.command = CMD_FORCED;
    it.chamber_index = 3'($urandom_range(7));
    it.sensor_slot = 4'($urandom_range(15));
    it.sensor_type = 16'($urandom);
    it.voltage = 16'($urandom);
    it.chamber_active = 1'($urandom);
    it.last_reading = 1'($urandom);
    it.now_ms = now_ms;
    return it;
  endfunction

  function automatic logic [15:0] next_volt();
    int v;
    if ($urandom_range(99) < 5) return 16'($urandom);
    v = level + $urandom_range(0, 3000) - 1500;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  task automatic run_observation();
    int act_ch, nc, ns;
    logic [15:0] ty;
    nc = eff_chambers();
    ns = eff_sensors();
    level += level_dir * $urandom_range(0, 2500);
    if (level > 60000 || level < 2000 || $urandom_range(99) < 8) level_dir = -level_dir;
    if (level < 0) level = 0;
    clock_ms += $urandom_range(0, 40);
    if ($urandom_range(99) < 6) begin
      drive_beat(forced_req(clock_ms));
      return;
    end
    act_ch = ($urandom_range(99) < 10) ? -1 : $urandom_range(0, nc - 1);
    if ($urandom_range(99) < 15)
      drive_beat(reading($urandom_range(7), $urandom_range(15), 16'($urandom),
                         16'($urandom), 1'($urandom), 1'b0, $urandom));
    for (int c = 0; c < nc; c++)
      for (int s = 0; s < ns; s++) begin
        ty = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(1, 3));
        drive_beat(reading(c, s, ty, next_volt(), c == act_ch,
                           c == nc - 1 && s == ns - 1, clock_ms));
      end
  endtask

  typedef struct {
    bit        is_cfg;
    cfg_idx_e  idx;
    logic [31:0] val;
    in_item_t  it;
    bit        typed_ok;
    out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic void add_cfg(cfg_idx_e idx, logic [31:0] val);
    dir_row_t r;
    r = '{1'b1, idx, val, '0, 1'b0, '0};
    dir_rows.push_back(r);
  endfunction

  function automatic void add_beat(in_item_t it, bit typed_ok = 1'b0, out_item_t want = '0);
    dir_row_t r;
    r = '{1'b0, CFG_STRATEGY_MODE, 0, it, typed_ok, want};
    dir_rows.push_back(r);
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    mode_r = MODE_NONE;
    mon_type_r = 0;
    min_ms_r = 0;
    decay_r = 0;
    min_diff_r = 0;
    nch_r = 4;
    nsens_r = 8;
    flag_bits = 0;
    recent_n = 0;
    peak_n = 0;
    peak_avg = 0;
    cur_avg = 0;
    last_sw = 0;
    clock_ms = 0;
    level = 20000;
    level_dir = 1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every store entry gets written before any evaluation
    for (int c = 0; c < CH_MAX; c++)
      for (int s = 0; s < SN_MAX; s++)
        drive_beat(reading(c, s, 16'($urandom_range(1, 3)), 16'($urandom), 1'b0,
                           c == CH_MAX - 1 && s == SN_MAX - 1, 0));

    // no flag set, no strategy
    add_beat(reading(0, 0, 16'h0000, 16'h0000, 1'b0, 1'b1, 0), 1'b1, '{0, 0, 0, 0, 0});
    add_beat(forced_req(0));
    add_cfg(CFG_STRATEGY_MODE, MODE_ALL_OPEN);
    add_beat(reading(2, 7, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 0), 1'b1, '{2, 1, 0, 1, 15});
    // out-of-range positions only touch the flags
    add_beat(reading(7, 15, 16'h1234, 16'hFFFF, 1'b1, 1'b0, 0));
    add_beat(reading(1, 9, 16'h0001, 16'h0000, 1'b0, 1'b0, 0));
    add_cfg(CFG_STRATEGY_MODE, MODE_PERIODIC);
    add_cfg(CFG_MIN_ACTIVE_MS, 0);
    add_beat(reading(2, 0, 16'h0002, 16'h0100, 1'b1, 1'b1, 1), 1'b1, '{2, 1, 0, 1, 3});
    add_beat(reading(3, 0, 16'h0002, 16'h0100, 1'b1, 1'b1, 1), 1'b1, '{2, 1, 0, 0, 0});
    add_cfg(CFG_MIN_ACTIVE_MS, 32'hFFFF_FFFF);
    add_beat(reading(3, 1, 16'h0003, 16'h0200, 1'b1, 1'b1, 0));
    add_cfg(CFG_STRATEGY_MODE, MODE_ADAPTIVE);
    add_cfg(CFG_MIN_ACTIVE_MS, 0);
    add_beat(reading(2, 1, 16'h0001, 16'hF000, 1'b1, 1'b1, 5));
    add_beat(reading(2, 1, 16'h0001, 16'h0000, 1'b1, 1'b1, 6));
    add_beat(reading(2, 1, 16'h0001, 16'h0000, 1'b1, 1'b1, 7));
    add_cfg(CFG_STRATEGY_MODE, MODE_DUAL);
    add_beat(reading(2, 2, 16'h0001, 16'h0010, 1'b0, 1'b0, 8));
    add_beat(reading(3, 2, 16'h0001, 16'h0010, 1'b0, 1'b1, 8));
    add_cfg(CFG_STRATEGY_MODE, 3'd7);
    add_cfg(CFG_CHAMBERS_IN_USE, 0);
    add_cfg(CFG_SENSORS_IN_USE, 0);
    add_beat(reading(1, 0, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 9));
    add_cfg(CFG_CHAMBERS_IN_USE, 15);
    add_cfg(CFG_SENSORS_IN_USE, 31);
    add_cfg(CFG_MONITORED_TYPE, 16'hFFFF);
    add_cfg(CFG_DECAY_THRESHOLD, 16'hFFFF);
    add_cfg(CFG_MIN_DIFFERENCE, 16'hFFFF);
    add_beat(forced_req(10));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        if (i == 0 || !dir_rows[i-1].is_cfg) wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
        if (i + 1 >= dir_rows.size() || !dir_rows[i+1].is_cfg) cfg_we <= 1'b0;
      end else begin
        drive_beat(dir_rows[i].it, dir_rows[i].typed_ok, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      write_reg(CFG_STRATEGY_MODE, ($urandom_range(9) == 0) ? $urandom_range(5, 7)
                                                             : (ph < 5 ? ph : $urandom_range(4)));
      write_reg(CFG_MONITORED_TYPE, ($urandom_range(5) == 0) ? $urandom : $urandom_range(0, 3));
      write_reg(CFG_MIN_ACTIVE_MS, (ph == 1) ? 32'hFFFF_FFFF : $urandom_range(0, 60));
      write_reg(CFG_DECAY_THRESHOLD, (ph == 1) ? 16'hFFFF : $urandom_range(0, 3000));
      write_reg(CFG_MIN_DIFFERENCE, (ph == 1) ? 16'hFFFF : $urandom_range(0, 2000));
      write_reg(CFG_CHAMBERS_IN_USE, (ph == 0) ? 2 : (ph == 1) ? 8 : $urandom_range(0, 15));
      write_reg(CFG_SENSORS_IN_USE, (ph == 0) ? 1 : (ph == 1) ? 16 :
                ($urandom_range(3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 3));
      cfg_we <= 1'b0;
      // time wraps through zero in some phases
      clock_ms = ($urandom_range(2) == 0) ? 32'hFFFF_FE00 + $urandom_range(0, 255) : $urandom;
      while (n_items < 80 + (ph + 1) * 160) run_observation();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
